FILE: design/deq_pkg.sv
`default_nettype none

package deq_pkg;

	localparam int DEQ_DEPTH = 16;
	localparam int DATA_W    = 32;
	localparam int COUNT_W   = 5;

	typedef enum logic [1:0] {
		OP_PUSH_BACK  = 2'd0,
		OP_PUSH_FRONT = 2'd1,
		OP_POP_BACK   = 2'd2,
		OP_POP_FRONT  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE       = 2'd0,
		ST_POP_EMPTY  = 2'd1,
		ST_PUSH_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]               operation;
		logic signed [DATA_W-1:0] push_value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] popped_value;
		logic [1:0]               status;
		logic [COUNT_W-1:0]       entry_count;
	} rsp_t;

endpackage

`default_nettype wire

FILE: design/deq_ram.sv
`default_nettype none

module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read data holds until the next read
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: design/double_ended_queue.sv
`default_nettype none

// Bounded double-ended queue of signed 32-bit words held in a ring buffer of
// DEPTH entries (one synchronous RAM plus front/back pointers and an entry
// count). Each request transfer carries one operation: push back, push front,
// pop back or pop front. Exactly one response transfer follows each request,
// in order, carrying the popped word (zero for pushes and for flagged
// operations), a status (done, pop on empty, push on full) and the entry count
// after the operation, masked to 5 bits. Flagged operations change nothing.
// Throughput is one request per cycle while req_stall is low: pointers and
// count are updated as the request is taken, so the next request sees them at
// once. The response passes through the read stage and then the response
// register: the RAM's registered read captures at the request edge, and the
// response register loads when the read stage advances. The RAM contents are not
// cleared at reset; a pop only ever reads an entry that a push has written. The
// request side stalls only when both the read stage and the response register
// are full and the response is being stalled.

module double_ended_queue
	import deq_pkg::*;
#(
	parameter int DEPTH = DEQ_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,

	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,

	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// pointers and count
	logic [AW-1:0] front_q, back_q, front_d, back_d;
	logic [CW-1:0] occ_q, occ_d;

	// read stage: RAM data arrives while the response metadata waits here
	logic                valid_s1;
	logic                is_pop_s1;
	status_t             status_s1;
	logic [COUNT_W-1:0]  count_s1;

	logic  rsp_valid_q;
	rsp_t  rsp_q;

	logic                accept;
	logic                s1_advance;
	op_t                 op;
	logic                full, empty;
	status_t             status_d;
	logic                is_pop_d;
	logic                ram_we, ram_re;
	logic [AW-1:0]       ram_waddr, ram_raddr;
	logic [DATA_W-1:0]   ram_rdata;
	logic [CW+COUNT_W-1:0] occ_ext;

	function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] i);
		return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
	endfunction

	function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] i);
		return (i == '0) ? AW'(DEPTH - 1) : i - AW'(1);
	endfunction

	assign op     = op_t'(req.operation);
	assign full   = (occ_q == CW'(DEPTH));
	assign empty  = (occ_q == '0);

	// s1 moves on whenever the response register is free or being taken
	assign s1_advance = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall  = valid_s1 && !s1_advance;
	assign accept     = req_valid && !req_stall;

	always_comb begin
		front_d   = front_q;
		back_d    = back_q;
		occ_d     = occ_q;
		status_d  = ST_DONE;
		is_pop_d  = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = back_q;
		ram_raddr = front_q;
		unique case (op)
			OP_PUSH_BACK: begin
				if (full) begin
					status_d = ST_PUSH_FULL;
				end else begin
					ram_we    = accept;
					ram_waddr = back_q;
					back_d    = slot_next(back_q);
					occ_d     = occ_q + CW'(1);
				end
			end
			OP_PUSH_FRONT: begin
				if (full) begin
					status_d = ST_PUSH_FULL;
				end else begin
					// move front down first, then write there
					front_d   = slot_prev(front_q);
					ram_we    = accept;
					ram_waddr = slot_prev(front_q);
					occ_d     = occ_q + CW'(1);
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					status_d = ST_POP_EMPTY;
				end else begin
					back_d    = slot_prev(back_q);
					ram_re    = accept;
					ram_raddr = slot_prev(back_q);
					is_pop_d  = 1'b1;
					occ_d     = occ_q - CW'(1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					status_d = ST_POP_EMPTY;
				end else begin
					ram_re    = accept;
					ram_raddr = front_q;
					front_d   = slot_next(front_q);
					is_pop_d  = 1'b1;
					occ_d     = occ_q - CW'(1);
				end
			end
			default: ;
		endcase
	end

	assign occ_ext = {{COUNT_W{1'b0}}, occ_d};

	deq_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(req.push_value),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			back_q   <= '0;
			occ_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				front_q  <= front_d;
				back_q   <= back_d;
				occ_q    <= occ_d;
				valid_s1 <= 1'b1;
			end else if (s1_advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_pop_s1 <= is_pop_d;
			status_s1 <= status_d;
			count_s1  <= occ_ext[COUNT_W-1:0];
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			if (s1_advance) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance) begin
			rsp_q.popped_value <= is_pop_s1 ? ram_rdata : '0;
			rsp_q.status       <= status_s1;
			rsp_q.entry_count  <= count_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

FILE: design/deq_checker.sv
`default_nettype none

module deq_checker
	import deq_pkg::*;
#(
	parameter int DEPTH = DEQ_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire req_t req,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW+COUNT_W-1:0] count_ext;
	assign count_ext = {{CW{1'b0}}, rsp.entry_count};

	// a stalled response holds
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// a stalled request holds
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req))
		else $error("stalled request changed");

	// flagged operations never return a word other than zero
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_DONE) |-> rsp.popped_value == '0)
		else $error("flagged response carries data");

	// count never exceeds capacity (checked where it fits in the field)
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (DEPTH < 32) |-> count_ext <= (CW+COUNT_W)'(DEPTH))
		else $error("entry count beyond capacity");

	// pop on empty reports an empty queue
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_POP_EMPTY) |-> rsp.entry_count == '0)
		else $error("pop on empty with nonzero count");

endmodule

bind double_ended_queue deq_checker #(.DEPTH(DEPTH)) u_deq_checker (.*);

`default_nettype wire

FILE: test/double_ended_queue_tb.sv
`timescale 1ns / 1ps

module double_ended_queue_tb;
	import deq_pkg::*;

	// Pending request plus the idle cycles the sender spends before it and
	// whether the sender first waits for the response side to drain.
	typedef struct {
		req_t        payload;
		int unsigned gap;
		bit          drain_first;
	} stim_t;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int TAIL_CYCLES    = 10;
	localparam int MAX_PRINTED    = 30;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	req_t req       = '0;
	logic rsp_stall = 1'b0;
	logic req_stall;
	logic rsp_valid;
	rsp_t rsp;

	double_ended_queue DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// Shadow deque: ring store, front/back slots and occupancy.
	// ---------------------------------------------------------------
	logic [DATA_W-1:0] shadow_store [DEQ_DEPTH];
	int unsigned       shadow_front = 0;
	int unsigned       shadow_back  = 0;
	int unsigned       shadow_count = 0;

	// what the run reached, for the closing summary
	int unsigned n_pops_ok   = 0;
	int unsigned n_pop_empty = 0;
	int unsigned n_push_full = 0;
	int unsigned n_push_ok   = 0;

	stim_t pending_q [$];
	rsp_t  expected_rsp_q [$];

	int unsigned total_items  = 0;
	int unsigned accepted_cnt = 0;  // driver only, blocking
	int unsigned checked_cnt  = 0;  // monitor only, nonblocking
	int unsigned err_cnt      = 0;
	bit          stim_ready   = 1'b0;

	// Apply one operation to the shadow deque and return the response it implies.
	function automatic rsp_t deq_apply(req_t r);
		rsp_t o;
		o = '0;
		o.status = ST_DONE;
		case (op_t'(r.operation))
		OP_PUSH_BACK, OP_PUSH_FRONT: begin
			if (shadow_count >= DEQ_DEPTH) begin
				o.status = ST_PUSH_FULL;
				n_push_full++;
			end else if (op_t'(r.operation) == OP_PUSH_BACK) begin
				shadow_store[shadow_back] = r.push_value;
				shadow_back = (shadow_back + 1) % DEQ_DEPTH;
				shadow_count++;
				n_push_ok++;
			end else begin
				// front moves down first, then the write lands there
				shadow_front = (shadow_front + DEQ_DEPTH - 1) % DEQ_DEPTH;
				shadow_store[shadow_front] = r.push_value;
				shadow_count++;
				n_push_ok++;
			end
		end
		default: begin
			if (shadow_count == 0) begin
				o.status = ST_POP_EMPTY;
				n_pop_empty++;
			end else if (op_t'(r.operation) == OP_POP_BACK) begin
				// back points one past the last entry: step down, then read
				shadow_back = (shadow_back + DEQ_DEPTH - 1) % DEQ_DEPTH;
				o.popped_value = shadow_store[shadow_back];
				shadow_count--;
				n_pops_ok++;
			end else begin
				o.popped_value = shadow_store[shadow_front];
				shadow_front = (shadow_front + 1) % DEQ_DEPTH;
				shadow_count--;
				n_pops_ok++;
			end
		end
		endcase
		o.entry_count = COUNT_W'(shadow_count);
		return o;
	endfunction

	// One line per mismatch, printing capped so a broken build stays readable.
	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		err_cnt++;
		if (err_cnt <= MAX_PRINTED)
			$display("[%0t] MISMATCH response %0d %s: got %0h, wanted %0h",
				$time, checked_cnt, what, got, want);
	endtask

	// ---------------------------------------------------------------
	// Sender: takes items from pending_q, holds valid steady while stalled,
	// and predicts each request at the edge where its transfer happens.
	// ---------------------------------------------------------------
	int unsigned gap_waited = 0;
	logic        nxt_valid;
	req_t        nxt_req;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid  <= 1'b0;
			req        <= '0;
			gap_waited = 0;
		end else begin
			nxt_valid = req_valid;
			nxt_req   = req;
			if (req_valid && !req_stall) begin
				expected_rsp_q.insert(expected_rsp_q.size(), deq_apply(req));
				accepted_cnt++;
				nxt_valid = 1'b0;
			end
			if (!nxt_valid && pending_q.size() != 0) begin
				// a drain item waits until every response so far has been checked;
				// checked_cnt is read before this edge's update, so this is race-free
				if (pending_q[0].drain_first && checked_cnt != accepted_cnt) begin
					gap_waited = 0;
				end else if (gap_waited < pending_q[0].gap) begin
					gap_waited++;
				end else begin
					nxt_req   = pending_q[0].payload;
					nxt_valid = 1'b1;
					pending_q.delete(0);
					gap_waited = 0;
				end
			end
			req_valid <= nxt_valid;
			req       <= nxt_req;
		end
	end

	// ---------------------------------------------------------------
	// Receiver: random stall per response, with calm stretches of none,
	// and a field-by-field compare against the oldest expectation.
	// ---------------------------------------------------------------
	int unsigned stall_left = 0;
	int unsigned calm_left  = 0;
	rsp_t        want_rsp;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall   <= 1'b0;
			checked_cnt <= 0;
			stall_left  = 0;
			calm_left   = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp_q.size() == 0) begin
					report_mismatch("unexpected transfer", rsp.popped_value, '0);
				end else begin
					want_rsp = expected_rsp_q[0];
					expected_rsp_q.delete(0);
					if (rsp.popped_value !== want_rsp.popped_value)
						report_mismatch("popped_value", rsp.popped_value,
							want_rsp.popped_value);
					if (rsp.status !== want_rsp.status)
						report_mismatch("status", 32'(rsp.status), 32'(want_rsp.status));
					if (rsp.entry_count !== want_rsp.entry_count)
						report_mismatch("entry_count", 32'(rsp.entry_count),
							32'(want_rsp.entry_count));
				end
				checked_cnt <= checked_cnt + 1;
				// draw the wait before the next response
				if (calm_left != 0) begin
					calm_left--;
					stall_left = 0;
				end else if ($urandom_range(0, 15) == 0) begin
					calm_left  = 40;
					stall_left = 0;
				end else begin
					stall_left = $urandom_range(0, 9);
				end
			end else if (stall_left != 0) begin
				stall_left--;
			end
			rsp_stall <= (stall_left != 0);
		end
	end

	// ---------------------------------------------------------------
	// Watchdog: only armed while responses are outstanding.
	// ---------------------------------------------------------------
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if (!stim_ready || checked_cnt == total_items
				|| (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] watchdog: no transfer for %0d cycles", $time, quiet_cycles);
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	task automatic add_item(op_t op, logic [31:0] val, int unsigned gap, bit drain);
		stim_t s;
		s.payload.operation  = op;
		s.payload.push_value = val;
		s.gap                = gap;
		s.drain_first        = drain;
		pending_q.insert(pending_q.size(), s);
		total_items++;
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 11))
		0:       return 32'h8000_0000;
		1:       return 32'h7FFF_FFFF;
		2:       return 32'hFFFF_FFFF;
		3:       return 32'h0000_0000;
		default: return $urandom;
		endcase
	endfunction

	int unsigned push_pct;
	bit          calm_phase;
	op_t         op_sel;

	initial begin
		// Directed: pops on an empty deque at both ends, then fill to full from both
		// ends, starting with extreme words, then pushes on full at both ends and one
		// pop from each end.
		add_item(OP_POP_BACK, 32'h1234_5678, 0, 1'b0);
		add_item(OP_POP_FRONT, 32'hFFFF_FFFF, 1, 1'b0);
		add_item(OP_PUSH_BACK, 32'h8000_0000, 0, 1'b0);
		add_item(OP_PUSH_FRONT, 32'h7FFF_FFFF, 0, 1'b0);
		add_item(OP_PUSH_BACK, 32'hFFFF_FFFF, 2, 1'b0);
		add_item(OP_PUSH_FRONT, 32'h0000_0000, 0, 1'b0);
		for (int i = 0; i < DEQ_DEPTH - 4; i++)
			add_item((i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom, 0, 1'b0);
		add_item(OP_PUSH_BACK, 32'hDEAD_BEEF, 0, 1'b0);
		add_item(OP_PUSH_FRONT, 32'h5555_AAAA, 0, 1'b0);
		add_item(OP_POP_BACK, 32'h0, 0, 1'b0);
		add_item(OP_POP_FRONT, 32'h0, 3, 1'b0);

		// Random: phases of 40 operations, each leaning towards pushes, pops or
		// neither, so the deque keeps reaching full and empty and the slots wrap.
		for (int p = 0; p < 30; p++) begin
			case ($urandom_range(0, 2))
			0:       push_pct = 15;
			1:       push_pct = 50;
			default: push_pct = 85;
			endcase
			calm_phase = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < 40; k++) begin
				if ($urandom_range(0, 99) < push_pct)
					op_sel = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
				else
					op_sel = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
				// every tenth phase opens by letting the response side drain
				add_item(op_sel, pick_value(), calm_phase ? 0 : $urandom_range(0, 9),
					(k == 0) && (p % 10 == 0));
			end
		end
		stim_ready = 1'b1;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (checked_cnt != total_items)
			@(posedge clk);
		// a stray late response would show up as an unexpected transfer here
		repeat (TAIL_CYCLES) @(posedge clk);

		if (expected_rsp_q.size() != 0)
			report_mismatch("responses never arrived", expected_rsp_q.size(), 0);

		$display("Ran %0d operations: %0d pushes stored, %0d words popped,",
			total_items, n_push_ok, n_pops_ok);
		$display("  %0d pops on an empty deque, %0d pushes on a full one.",
			n_pop_empty, n_push_full);
		if (err_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

FILE: sim.f
design/deq_pkg.sv
design/deq_ram.sv
design/double_ended_queue.sv
design/deq_checker.sv
test/double_ended_queue_tb.sv
